// ===== rtl/nfsa_pkg.sv =====
package nfsa_pkg;

  // Default table depth.
  localparam int unsigned SlotsDefault = 1024;

  // Width of a requested or granted slot number on the streams.
  localparam int unsigned ReqW = 10;

  // tdata width, padded to whole bytes.
  localparam int unsigned TdataW = 16;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_req;    // take the request and read its entry
    logic clear_step;  // zero one entry of the table
    logic chase_step;  // follow the pointer just read
    logic grant;       // mark the found slot taken, restart at the request
    logic comp_step;   // rewrite one path entry and follow it
    logic load_out;    // move the answer into the output register
    logic set_none;    // the answer is "no free slot"
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic req_beyond;  // offered request lies past the table
    logic cur_end;     // current pointer is past the table
    logic entry_free;  // entry just read is zero
    logic ptr_bad;     // entry just read does not point upward
    logic path_more;   // current pointer is still below the granted slot
    logic clear_last;  // clearing pass is at the last entry
    logic out_free;    // output register can take an answer
  } sts_t;

endpackage

// ===== rtl/nfsa_ctrl.sv =====
module nfsa_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  input  nfsa_pkg::sts_t sts_i,
  output nfsa_pkg::cmd_t cmd_o
);
  import nfsa_pkg::*;

  typedef enum logic [2:0] {
    StClear,
    StIdle,
    StChase,
    StComp,
    StDoneOk,
    StDoneNone
  } state_e;

  state_e state_q, state_d;

  assign s_axis_tready = (state_q == StIdle);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      StClear: begin
        cmd_o.clear_step = 1'b1;
        if (sts_i.clear_last) begin
          state_d = StIdle;
        end
      end
      StIdle: begin
        if (s_axis_tvalid) begin
          if (sts_i.req_beyond) begin
            state_d = StDoneNone;
          end else begin
            cmd_o.load_req = 1'b1;
            state_d        = StChase;
          end
        end
      end
      StChase: begin
        if (sts_i.cur_end) begin
          state_d = StDoneNone;
        end else if (sts_i.entry_free) begin
          cmd_o.grant = 1'b1;
          state_d     = StComp;
        end else if (sts_i.ptr_bad) begin
          state_d = StDoneNone;
        end else begin
          cmd_o.chase_step = 1'b1;
        end
      end
      StComp: begin
        if (sts_i.path_more) begin
          cmd_o.comp_step = 1'b1;
        end else begin
          state_d = StDoneOk;
        end
      end
      StDoneOk: begin
        if (sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = StIdle;
        end
      end
      StDoneNone: begin
        if (sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          cmd_o.set_none = 1'b1;
          state_d        = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StClear;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== rtl/nfsa_dpath.sv =====
module nfsa_dpath #(
  parameter int unsigned SLOTS = nfsa_pkg::SlotsDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [nfsa_pkg::TdataW-1:0]   s_axis_tdata,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [nfsa_pkg::TdataW-1:0]   m_axis_tdata,
  output logic                          m_axis_tuser,
  input  nfsa_pkg::cmd_t                cmd_i,
  output nfsa_pkg::sts_t                sts_o
);
  import nfsa_pkg::*;

  // Entry width holds every slot number and the past-the-end value SLOTS.
  localparam int unsigned AW = $clog2(SLOTS);
  localparam int unsigned PW = $clog2(SLOTS + 1);

  logic [PW-1:0] mem [SLOTS];

  logic [PW-1:0]   cur_q, cur_d;
  logic [PW-1:0]   req_q, req_d;
  logic [PW-1:0]   slot_q, slot_d;
  logic [PW-1:0]   rdata_q;
  logic [AW-1:0]   raddr;
  logic [AW-1:0]   waddr;
  logic [PW-1:0]   wdata;
  logic            we;
  logic [ReqW-1:0] out_slot_q, out_slot_d;
  logic            out_none_q, out_none_d;
  logic            out_valid_q, out_valid_d;
  logic [ReqW-1:0] s_req;

  assign s_req = s_axis_tdata[ReqW-1:0];

  always_comb begin
    cur_d  = cur_q;
    req_d  = req_q;
    slot_d = slot_q;
    raddr  = cur_q[AW-1:0];
    waddr  = cur_q[AW-1:0];
    wdata  = '0;
    we     = 1'b0;
    if (cmd_i.load_req) begin
      cur_d = PW'(s_req);
      req_d = PW'(s_req);
      raddr = AW'(s_req);
    end
    if (cmd_i.clear_step) begin
      we    = 1'b1;
      cur_d = cmd_i.clear_step && sts_o.clear_last ? '0 : cur_q + PW'(1);
    end
    if (cmd_i.chase_step) begin
      cur_d = rdata_q;
      raddr = rdata_q[AW-1:0];
    end
    if (cmd_i.grant) begin
      we     = 1'b1;
      wdata  = cur_q + PW'(1);
      slot_d = cur_q;
      cur_d  = req_q;
      raddr  = req_q[AW-1:0];
    end
    if (cmd_i.comp_step) begin
      we    = 1'b1;
      wdata = slot_q + PW'(1);
      cur_d = rdata_q;
      raddr = rdata_q[AW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_q <= mem[raddr];
    req_q   <= req_d;
    slot_q  <= slot_d;
  end

  // The entry counter doubles as the clearing counter, so it is reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q <= '0;
    end else begin
      cur_q <= cur_d;
    end
  end

  always_comb begin
    sts_o.req_beyond = 32'(s_req) >= 32'(SLOTS);
    sts_o.cur_end    = cur_q == PW'(SLOTS);
    sts_o.entry_free = rdata_q == '0;
    sts_o.ptr_bad    = rdata_q <= cur_q;
    sts_o.path_more  = cur_q < slot_q;
    sts_o.clear_last = cur_q == PW'(SLOTS - 1);
    sts_o.out_free   = !out_valid_q || m_axis_tready;
  end

  always_comb begin
    out_valid_d = out_valid_q && !m_axis_tready;
    out_slot_d  = out_slot_q;
    out_none_d  = out_none_q;
    if (cmd_i.load_out) begin
      out_valid_d = 1'b1;
      out_none_d  = cmd_i.set_none;
      out_slot_d  = cmd_i.set_none ? '0 : ReqW'(slot_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_slot_q <= out_slot_d;
    out_none_q <= out_none_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(TdataW - ReqW){1'b0}}, out_slot_q};
  assign m_axis_tuser  = out_none_q;

endmodule

// ===== rtl/next_free_slot_allocator.sv =====
// A request is answered only after its chase, one step per pointer hop, and its path rewrite,
// one step per rewritten entry; a request that finds its slot free needs no hop and no rewrite.
// Requests are taken one at a time, and each entry visit uses the single table read port;
// an exhausted request skips the grant and the path rewrite and is answered with none_free.
// Reset: asynchronous, active low; afterwards a clearing pass writes zero to the table,
// one entry per cycle, with s_axis_tready low until it ends.
module next_free_slot_allocator #(
  parameter int unsigned SLOTS = nfsa_pkg::SlotsDefault
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // Request stream.
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [nfsa_pkg::TdataW-1:0] s_axis_tdata,   // [9:0] requested_slot, rest zero
  // Grant stream.
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [nfsa_pkg::TdataW-1:0] m_axis_tdata,   // [9:0] granted_slot, rest zero
  output logic                        m_axis_tuser    // [0] none_free
);
  import nfsa_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // The controller walks each request through its phases: chase the next pointers
  // up to the first zero entry, mark that slot taken, then walk the same path again
  // rewriting every entry to point just past the grant, or answer none_free if the chase fails.
  nfsa_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .sts_i         (sts),
    .cmd_o         (cmd)
  );

  // The datapath holds the pointer table, the walk registers and the
  // output register, so a finished grant can wait while the next request
  // is accepted.
  nfsa_dpath #(
    .SLOTS (SLOTS)
  ) u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cmd_i         (cmd),
    .sts_o         (sts)
  );

  // A request is worked on alone: after one is accepted, none follows next cycle.
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("request accepted while another is in progress");

  // A none_free answer carries slot zero.
  a_none_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0)
    else $error("none_free answer with nonzero slot");

  // A grant always names a slot inside the table.
  a_grant_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> 32'(m_axis_tdata[ReqW-1:0]) < 32'(SLOTS))
    else $error("granted slot beyond the table");

  // The controller never issues a grant and an output load together.
  a_cmd_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd.grant && cmd.load_out))
    else $error("grant and output load in the same cycle");

endmodule

// ===== bench/nfsa_checker.sv =====
`timescale 1ns / 100ps

// Watches both streams of the allocator, keeps its own copy of the
// next-pointer table and checks every grant against the oldest request.
module nfsa_checker #(
  parameter int unsigned SLOTS = nfsa_pkg::SlotsDefault
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid,
  input  logic                        s_axis_tready,
  input  logic [nfsa_pkg::TdataW-1:0] s_axis_tdata,   // [9:0] requested_slot
  input  logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  input  logic [nfsa_pkg::TdataW-1:0] m_axis_tdata,   // [9:0] granted_slot
  input  logic                        m_axis_tuser,   // [0] none_free
  output int unsigned                 pending_o,
  output int unsigned                 mismatches_o
);

  import nfsa_pkg::*;

  // An entry holds 0 (free) up to SLOTS (past the end).
  localparam int unsigned LinkW = $clog2(SLOTS + 1);

  typedef struct packed {
    logic [ReqW-1:0] slot;
    logic            none_free;
  } grant_t;

  logic [LinkW-1:0] slot_link [SLOTS];
  grant_t           expected_grants [$];

  // Finds the lowest free slot at or above the request, takes it and points
  // every entry on the chased path past it. An exhausted range leaves the
  // table untouched.
  function automatic grant_t allocate_slot(input logic [ReqW-1:0] req);
    int unsigned cur;
    int unsigned nxt;
    int unsigned hit;
    grant_t      g;
    g.slot      = '0;
    g.none_free = 1'b1;
    cur = req;
    if (cur >= SLOTS) return g;
    while (cur < SLOTS && slot_link[cur] != '0) begin
      nxt = slot_link[cur];
      if (nxt <= cur) return g;
      cur = nxt;
    end
    if (cur >= SLOTS) return g;
    hit = cur;
    slot_link[hit] = LinkW'(hit + 1);
    cur = req;
    while (cur < hit) begin
      nxt = slot_link[cur];
      slot_link[cur] = LinkW'(hit + 1);
      if (nxt <= cur) break;
      cur = nxt;
    end
    g.slot      = ReqW'(hit);
    g.none_free = 1'b0;
    return g;
  endfunction

  task automatic report_mismatch(input string what);
    $display("[%0t] grant mismatch: %s", $time, what);
    mismatches_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : grant_check
    grant_t want;
    if (!rst_ni) begin
      foreach (slot_link[i]) slot_link[i] = '0;
      expected_grants.delete();
      mismatches_o = 0;
      pending_o   <= 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        expected_grants.insert(expected_grants.size(),
                               allocate_slot(s_axis_tdata[ReqW-1:0]));
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_grants.size() == 0) begin
          report_mismatch($sformatf("grant slot %0d none_free %0b with no request waiting",
                                    m_axis_tdata[ReqW-1:0], m_axis_tuser));
        end else begin
          want = expected_grants.pop_front();
          if (m_axis_tdata[ReqW-1:0] !== want.slot) begin
            report_mismatch($sformatf("granted_slot %0d, expected %0d",
                                      m_axis_tdata[ReqW-1:0], want.slot));
          end
          if (m_axis_tuser !== want.none_free) begin
            report_mismatch($sformatf("none_free %0b, expected %0b",
                                      m_axis_tuser, want.none_free));
          end
        end
      end
      pending_o <= expected_grants.size();
    end
  end

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 100ps

module tb;

  import nfsa_pkg::*;

  localparam int unsigned SLOTS          = SlotsDefault;
  localparam int unsigned RandomRequests = 1400;
  localparam int unsigned HoldoffCycles  = 3000;
  localparam int unsigned SettleCycles   = 64;
  // Worst case per request: a full chase plus a full path rewrite, both gaps.
  localparam longint unsigned RunLimit =
      3 * ((RandomRequests + 50) * (4 + 2 * SLOTS + 10) + SLOTS + HoldoffCycles);

  typedef enum int unsigned {RunRepeat, RunUniform, RunDescending} run_kind_e;

  logic              clk_i         = 1'b0;
  logic              rst_ni        = 1'b0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [TdataW-1:0] s_axis_tdata  = '0;
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [TdataW-1:0] m_axis_tdata;
  logic              m_axis_tuser;

  int unsigned     pending;
  int unsigned     mismatches;
  int unsigned     idle_max     = 5;
  int unsigned     sink_holdoff = 0;
  longint unsigned cycles       = 0;

  // Requests that hit the extremes, repeat a taken slot, walk a chain and
  // run off the top of the table.
  int unsigned directed_reqs [20] = '{0, 0, 1, 1023, 1023, 1022, 1022, 1021, 512, 512,
                                      511, 511, 341, 682, 0, 2, 1020, 1019, 1019, 1000};

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  next_free_slot_allocator #(
    .SLOTS(SLOTS)
  ) i_dut (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata,
    .m_axis_tuser
  );

  nfsa_checker #(
    .SLOTS(SLOTS)
  ) i_checker (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata,
    .m_axis_tuser,
    .pending_o    (pending),
    .mismatches_o (mismatches)
  );

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == RunLimit) begin
      $display("next_free_slot_allocator test failed");
      $finish;
    end
  end

  // Offers one request after a random gap; valid stays high when the gap is zero.
  task automatic send_request(input logic [ReqW-1:0] req);
    int unsigned gap;
    gap = $urandom_range(0, idle_max);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(TdataW - ReqW){1'b0}}, req};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  // Grant side: random stalls, and one long hold-off when asked for.
  initial begin : grant_sink
    int unsigned stall;
    wait (rst_ni);
    forever begin
      if (sink_holdoff != 0) begin
        stall = sink_holdoff;
        sink_holdoff = 0;
      end else begin
        stall = $urandom_range(0, idle_max);
      end
      if (stall != 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk_i);
      while (!m_axis_tvalid) @(posedge clk_i);
    end
  end

  initial begin : request_source
    int unsigned sent;
    int unsigned run_len;
    int unsigned base;
    int unsigned req;
    run_kind_e   kind;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_reqs[i]) send_request(ReqW'(directed_reqs[i]));

    // Let the directed requests drain before the random part starts. The
    // pending count is registered, so it lags the accepting edge.
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);

    sent = 0;
    while (sent < RandomRequests) begin
      kind    = run_kind_e'($urandom_range(0, 2));
      run_len = $urandom_range(1, 16);
      base    = $urandom_range(0, 1023);
      for (int unsigned k = 0; k < run_len && sent < RandomRequests; k++) begin
        case (kind)
          RunRepeat:     req = base;
          RunUniform:    req = $urandom_range(0, 1023);
          RunDescending: req = (base >= k) ? base - k : 0;
          default:       req = base;
        endcase
        if (sent == 300) idle_max = 0;
        if (sent == 450) idle_max = 5;
        if (sent == 600) sink_holdoff = HoldoffCycles;
        if (sent == 900) begin
          // Hold the request stream until the block has answered everything.
          s_axis_tvalid <= 1'b0;
          @(posedge clk_i);
          while (pending != 0) @(posedge clk_i);
        end
        if (sent == 1100) idle_max = 0;
        if (sent == 1200) idle_max = 5;
        send_request(ReqW'(req));
        sent++;
      end
    end
    s_axis_tvalid <= 1'b0;

    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("next_free_slot_allocator test passed");
    end else begin
      $display("next_free_slot_allocator test failed");
    end
    $finish;
  end

endmodule
